// ===== design/tensor_swapaxes_index_remap_defines.svh =====
// assertion macros for the axis swap index remapper
`ifndef TENSOR_SWAPAXES_INDEX_REMAP_DEFINES_SVH
`define TENSOR_SWAPAXES_INDEX_REMAP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSIR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TSIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tsir_pkg.sv =====
// shared constants, register indexes and configuration type of the index remapper
package tsir_pkg;

	localparam int MAX_DIMS_DEF   = 4;
	localparam int INDEX_BITS_DEF = 24;
	localparam int DIM_BITS_DEF   = 12;

	localparam int SIZE_REGS  = 4;
	localparam int SIZE_W     = 13;
	localparam int COUNT_W    = 3;
	localparam int AXIS_W     = 3;
	localparam int ELEM_W     = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 13;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_DIM_COUNT   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DIM_SIZE_0  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DIM_SIZE_1  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DIM_SIZE_2  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DIM_SIZE_3  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_AXIS_FIRST  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_AXIS_SECOND = 3'd6;

	// register file contents
	typedef struct packed {
		logic [COUNT_W-1:0]                 dim_count;
		logic [SIZE_REGS-1:0][SIZE_W-1:0]   dim_size;
		logic [AXIS_W-1:0]                  axis_first;
		logic [AXIS_W-1:0]                  axis_second;
	} cfg_t;

endpackage

// ===== design/tsir_shape.sv =====
// shape derivation: clamped extents, source strides, element count, permuted destination strides
module tsir_shape #(
	parameter int MAX_DIMS   = tsir_pkg::MAX_DIMS_DEF,
	parameter int INDEX_BITS = tsir_pkg::INDEX_BITS_DEF,
	parameter int DIM_BITS   = tsir_pkg::DIM_BITS_DEF
) (
	input  logic                  clk,
	input  tsir_pkg::cfg_t        cfg,
	output logic [INDEX_BITS:0]   sstr [MAX_DIMS],
	output logic [INDEX_BITS-1:0] dperm [MAX_DIMS],
	output logic [INDEX_BITS:0]   count,
	output logic                  axis_err,
	output logic                  axes_equal
);

	localparam int NW = $clog2(MAX_DIMS + 1);
	localparam int AW = $clog2(MAX_DIMS);
	localparam int EW = DIM_BITS + 1;
	localparam int SW = INDEX_BITS + 1;
	localparam int PW = SW + EW;
	localparam logic [PW-1:0] IDX_CAP = {{(PW-1){1'b0}}, 1'b1} << INDEX_BITS;
	localparam logic [31:0]   EXT_CAP = 32'd1 << DIM_BITS;

	logic [NW-1:0]       n_c;
	logic [EW-1:0]       ext_c [MAX_DIMS];
	logic [AW-1:0]       ax1_c, ax2_c;
	logic                err_c;
	logic [EW-1:0]       ext_q [MAX_DIMS];
	logic [AW-1:0]       ax1_q, ax2_q;
	logic                err_q;
	logic [EW-1:0]       sw_c [MAX_DIMS];
	logic [SW-1:0]       sstr_q [MAX_DIMS];
	logic [INDEX_BITS-1:0] dstr_q [MAX_DIMS];
	logic [INDEX_BITS-1:0] dperm_q [MAX_DIMS];
	logic [SW-1:0]       count_q;

	// multiply with saturation at the index range
	function automatic logic [SW-1:0] sat_mul(input logic [SW-1:0] a, input logic [EW-1:0] b);
		logic [PW-1:0] p;
		p = PW'(a) * PW'(b);
		return (p > IDX_CAP) ? SW'(IDX_CAP) : SW'(p);
	endfunction

	// dimension count clamp
	always_comb begin
		if (cfg.dim_count == '0)
			n_c = NW'(1);
		else if (32'(cfg.dim_count) > 32'(MAX_DIMS))
			n_c = NW'(MAX_DIMS);
		else
			n_c = NW'(cfg.dim_count);
	end

	// clamped extents, unused axes have extent one
	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_ext
		if (k < tsir_pkg::SIZE_REGS) begin : g_reg
			always_comb begin
				if (32'(k) >= 32'(n_c) || cfg.dim_size[k] == '0)
					ext_c[k] = EW'(1);
				else if ({19'b0, cfg.dim_size[k]} > EXT_CAP)
					ext_c[k] = EW'(EXT_CAP);
				else
					ext_c[k] = EW'(cfg.dim_size[k]);
			end
		end else begin : g_one
			assign ext_c[k] = EW'(1);
		end
	end

	// axis normalisation and range check
	always_comb begin
		int a1, a2, nn;
		nn = int'(n_c);
		a1 = $signed({{29{cfg.axis_first[2]}}, cfg.axis_first});
		a2 = $signed({{29{cfg.axis_second[2]}}, cfg.axis_second});
		err_c = (a1 < -nn) || (a1 >= nn) || (a2 < -nn) || (a2 >= nn);
		ax1_c = AW'((a1 < 0) ? a1 + nn : a1);
		ax2_c = AW'((a2 < 0) ? a2 + nn : a2);
	end

	always_ff @(posedge clk) begin
		ext_q <= ext_c;
		ax1_q <= ax1_c;
		ax2_q <= ax2_c;
		err_q <= err_c;
	end

	// swapped extents
	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			sw_c[k] = EW'(1);
			for (int j = 0; j < MAX_DIMS; j++) begin
				if ((32'(k) == 32'(ax1_q) && 32'(j) == 32'(ax2_q)) ||
				    (32'(k) == 32'(ax2_q) && 32'(k) != 32'(ax1_q) && 32'(j) == 32'(ax1_q)) ||
				    (32'(k) != 32'(ax1_q) && 32'(k) != 32'(ax2_q) && j == k))
					sw_c[k] = ext_q[j];
			end
		end
	end

	// stride chains, one multiply per register
	always_ff @(posedge clk) begin
		sstr_q[MAX_DIMS-1] <= SW'(1);
		dstr_q[MAX_DIMS-1] <= INDEX_BITS'(1);
		for (int k = 0; k < MAX_DIMS - 1; k++) begin
			sstr_q[k] <= sat_mul(sstr_q[k+1], ext_q[k+1]);
			dstr_q[k] <= INDEX_BITS'(dstr_q[k+1] * sw_c[k+1]);
		end
		count_q <= sat_mul(sstr_q[0], ext_q[0]);
	end

	// destination stride seen by each source axis
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			dperm_q[k] <= dstr_q[k];
			for (int j = 0; j < MAX_DIMS; j++) begin
				if ((32'(k) == 32'(ax1_q) && 32'(j) == 32'(ax2_q)) ||
				    (32'(k) == 32'(ax2_q) && 32'(j) == 32'(ax1_q)))
					dperm_q[k] <= dstr_q[j];
			end
		end
	end

	assign sstr       = sstr_q;
	assign dperm      = dperm_q;
	assign count      = count_q;
	assign axis_err   = err_q;
	assign axes_equal = (ax1_q == ax2_q);

endmodule

// ===== design/tensor_swapaxes_index_remap.sv =====
// top level: register file, unravel and ravel pipeline, output register
// Remaps the row-major linear index of each incoming element to its index in the tensor
// with two axes exchanged; one word is taken per clock while the pipeline advances and
// the input is not held off. Each word passes the entry stage, then the unravel, which
// finds one quotient bit of one coordinate per pipeline stage and spends one more stage
// per axis on the stride multiply, and then the output register. A held result stalls
// the whole pipeline. Shape, stride and count values are derived from the registers
// through a short registered chain; the input is held off in the cycle of a register
// write and after it, and after reset, until the settle counter has run down, so no
// word enters before those values have settled. A word with an axis or index error
// leaves with a destination index of zero.
module tensor_swapaxes_index_remap #(
	parameter int MAX_DIMS   = tsir_pkg::MAX_DIMS_DEF,
	parameter int INDEX_BITS = tsir_pkg::INDEX_BITS_DEF,
	parameter int DIM_BITS   = tsir_pkg::DIM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [tsir_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tsir_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	// source_index, element_bits
	input  logic [((INDEX_BITS+tsir_pkg::ELEM_W+7)/8)*8-1:0] s_tdata,
	// output stream
	output logic m_tvalid,
	input  logic m_tready,
	// dest_index, element_out
	output logic [((INDEX_BITS+tsir_pkg::ELEM_W+7)/8)*8-1:0] m_tdata,
	// axis_error, index_out_of_range
	output logic [1:0] m_tuser
);

`include "tensor_swapaxes_index_remap_defines.svh"

	localparam int DB     = DIM_BITS;
	localparam int IB     = INDEX_BITS;
	localparam int EL     = tsir_pkg::ELEM_W;
	localparam int STEPS  = DB + 1;
	localparam int NSTG   = MAX_DIMS * STEPS;
	localparam int TW     = IB + 1 + DB;
	localparam int OW     = ((IB + EL + 7) / 8) * 8;
	localparam int SETTLE = MAX_DIMS + 1;
	localparam int SCW    = $clog2(SETTLE + 1);

	typedef struct packed {
		logic [IB-1:0] src;
		logic [EL-1:0] elem;
		logic          aerr;
		logic          oor;
		logic [IB-1:0] rem;
		logic [DB-1:0] quo;
		logic [IB-1:0] prod;
		logic [IB-1:0] acc;
	} stg_t;

	tsir_pkg::cfg_t cfg_q;
	logic [IB:0]    sstr [MAX_DIMS];
	logic [IB-1:0]  dperm [MAX_DIMS];
	logic [IB:0]    count;
	logic           axis_err, axes_equal;
	logic           ce;
	logic [SCW-1:0] settle_q;

	stg_t pipe_s [NSTG+1];
	logic vld_s  [NSTG+1];

	logic          out_vld_q;
	logic [IB-1:0] dest_q;
	logic [EL-1:0] elem_q;
	logic          aerr_q, oor_q;
	logic [IB-1:0] dest_c;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_count   <= tsir_pkg::COUNT_W'(2);
			cfg_q.dim_size    <= {tsir_pkg::SIZE_REGS{tsir_pkg::SIZE_W'(1)}};
			cfg_q.axis_first  <= tsir_pkg::AXIS_W'(0);
			cfg_q.axis_second <= tsir_pkg::AXIS_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				tsir_pkg::REG_DIM_COUNT:   cfg_q.dim_count   <= cfg_wdata[2:0];
				tsir_pkg::REG_DIM_SIZE_0:  cfg_q.dim_size[0] <= cfg_wdata;
				tsir_pkg::REG_DIM_SIZE_1:  cfg_q.dim_size[1] <= cfg_wdata;
				tsir_pkg::REG_DIM_SIZE_2:  cfg_q.dim_size[2] <= cfg_wdata;
				tsir_pkg::REG_DIM_SIZE_3:  cfg_q.dim_size[3] <= cfg_wdata;
				tsir_pkg::REG_AXIS_FIRST:  cfg_q.axis_first  <= cfg_wdata[2:0];
				tsir_pkg::REG_AXIS_SECOND: cfg_q.axis_second <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// hold off input while the derived shape values settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			settle_q <= SCW'(SETTLE);
		else if (cfg_we)
			settle_q <= SCW'(SETTLE);
		else if (settle_q != '0)
			settle_q <= settle_q - SCW'(1);
	end

	tsir_shape #(
		.MAX_DIMS   (MAX_DIMS),
		.INDEX_BITS (INDEX_BITS),
		.DIM_BITS   (DIM_BITS)
	) u_shape (
		.clk        (clk),
		.cfg        (cfg_q),
		.sstr       (sstr),
		.dperm      (dperm),
		.count      (count),
		.axis_err   (axis_err),
		.axes_equal (axes_equal)
	);

	// whole pipeline advances unless a result is held
	assign ce       = !out_vld_q || m_tready;
	assign s_tready = ce && !cfg_we && (settle_q == '0);

	// entry stage: capture word, range checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (ce)
			vld_s[0] <= s_tvalid && s_tready;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			pipe_s[0].src  <= s_tdata[IB-1:0];
			pipe_s[0].elem <= s_tdata[IB +: EL];
			pipe_s[0].aerr <= axis_err;
			pipe_s[0].oor  <= {1'b0, s_tdata[IB-1:0]} >= count;
			pipe_s[0].rem  <= s_tdata[IB-1:0];
			pipe_s[0].quo  <= '0;
			pipe_s[0].prod <= '0;
			pipe_s[0].acc  <= '0;
		end
	end

	// unravel by restoring division, one quotient bit per stage, then stride multiply
	for (genvar s = 0; s < NSTG; s++) begin : g_stage
		localparam int D = s / STEPS;
		localparam int J = s % STEPS;
		stg_t nxt;

		if (J < DB) begin : g_div
			localparam int B = DB - 1 - J;
			logic [TW-1:0] trial;
			assign trial = TW'(sstr[D]) << B;
			always_comb begin
				nxt = pipe_s[s];
				// fold the previous axis product into the sum
				if (J == 0) begin
					nxt.acc  = pipe_s[s].acc + pipe_s[s].prod;
					nxt.prod = '0;
					nxt.quo  = '0;
				end
				if (TW'(pipe_s[s].rem) >= trial) begin
					nxt.rem    = pipe_s[s].rem - IB'(trial);
					nxt.quo[B] = 1'b1;
				end
			end
		end else begin : g_mul
			logic [IB+DB-1:0] mp;
			assign mp = pipe_s[s].quo * dperm[D];
			always_comb begin
				nxt      = pipe_s[s];
				nxt.prod = mp[IB-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[s+1] <= 1'b0;
			else if (ce)
				vld_s[s+1] <= vld_s[s];
		end

		always_ff @(posedge clk) begin
			if (ce)
				pipe_s[s+1] <= nxt;
		end
	end

	// final sum, pass-through of the source index for equal axes, and error masking
	always_comb begin
		if (pipe_s[NSTG].aerr || pipe_s[NSTG].oor)
			dest_c = '0;
		else if (axes_equal)
			dest_c = pipe_s[NSTG].src;
		else
			dest_c = pipe_s[NSTG].acc + pipe_s[NSTG].prod;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (ce)
			out_vld_q <= vld_s[NSTG];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dest_q <= dest_c;
			elem_q <= pipe_s[NSTG].elem;
			aerr_q <= pipe_s[NSTG].aerr;
			oor_q  <= pipe_s[NSTG].oor;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OW'({elem_q, dest_q});
	assign m_tuser  = {oor_q, aerr_q};

	// checks
	`TSIR_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser != 2'b00), m_tdata[IB-1:0] == '0, "flagged word has nonzero index")
	`TSIR_ASSERT_NOW(a_dest_range, m_tvalid && (m_tuser == 2'b00), {1'b0, m_tdata[IB-1:0]} < count, "destination index beyond element count")
	`TSIR_ASSERT_NEXT(a_entry, s_tvalid && s_tready, vld_s[0], "accepted word missing from entry stage")

endmodule
